// ----- design/sfr_pkg.sv -----
// shared types, constants and crc helper for the serial frame receiver
package sfr_pkg;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_BAD_SUM = 3'd1,
		KIND_BAD_CRC = 3'd2,
		KIND_BAD_LEN = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	localparam logic [1:0]  REG_TIMEOUT   = 2'd0;
	localparam logic [1:0]  REG_MIN_LEN   = 2'd1;

	localparam logic [7:0]  PREAMBLE      = 8'hFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [5:0]  MIN_LEN_RESET = 6'd8;
	localparam int unsigned TRAILER_BYTES = 3;

	// one byte of reflected crc-16, bit at a time
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ----- design/serial_frame_receiver_core.sv -----
// uart frame deframer: preamble hunt, frame buffer, sum and crc check, frame readout
//
//  channel  | signals                                  | contents
//  ---------+------------------------------------------+------------------------------------
//  s_axis   | tvalid tready tdata[7:0] tuser[0]        | rx byte; tuser 1 = tick request
//  m_axis   | tvalid tready tdata[15:0] tuser[2:0] tlast | frame byte or status result
//  cfg      | valid ready index[1:0] data[15:0]        | register write
//
//  a byte or tick request is handled as it is taken; a good frame of n bytes is read back out of
//  the frame memory through a registered read, one byte per cycle while m_axis_tready holds,
//  and no request is taken during that readout.
//  s_axis_tready is low while the output register holds an untaken result.
//  reset clears all control state; the frame memory is not cleared and needs no sweep.
module serial_frame_receiver_core #(
	parameter int MAX_FRAME = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index, [15:14] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int FW = $clog2(MAX_FRAME + 1);
	localparam int AW = $clog2(MAX_FRAME);
	localparam logic [9:0] MAX_W = 10'(MAX_FRAME);

	typedef enum logic {ST_RUN, ST_EMIT} state_t;

	state_t        st_q;
	logic [15:0]   timeout_q;
	logic [5:0]    min_len_q;
	logic [1:0]    pre_q;
	logic [FW-1:0] size_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    sum_q;
	logic [15:0]   crc_q;
	logic [15:0]   ticks_q;
	logic [7:0]    sumb_q;
	logic [7:0]    crch_q;
	logic [FW-1:0] rd_q;

	logic          s1_valid_q;
	logic [7:0]    rdata_s1;
	logic [5:0]    idx_s1;
	logic          last_s1;

	logic                 out_valid_q;
	sfr_pkg::kind_t       out_kind_q;
	logic [7:0]           out_data_q;
	logic [5:0]           out_idx_q;
	logic                 out_last_q;

	logic [7:0] frame_mem [MAX_FRAME];

	logic          accept, is_tick, hunting, len_ok, tick_expire, final_byte, move, rd_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    val;
	logic [5:0]    min_eff;
	logic [15:0]   ticks_inc;
	logic [FW-1:0] len_w, fill_inc;
	logic [15:0]   crc_next;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == ST_RUN) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_idx_q, out_data_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		accept      = s_axis_tvalid && s_axis_tready;
		is_tick     = s_axis_tuser;
		val         = s_axis_tdata;
		hunting     = (size_q == '0);
		min_eff     = (min_len_q == 6'd0) ? 6'd1 : min_len_q;
		len_ok      = (({2'b00, val} + 10'd3) <= MAX_W) && (val >= {2'b00, min_eff});
		ticks_inc   = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
		tick_expire = (ticks_inc >= timeout_q);
		len_w       = size_q - FW'(sfr_pkg::TRAILER_BYTES);
		fill_inc    = fill_q + FW'(1);
		final_byte  = (fill_inc == size_q);
		crc_next    = sfr_pkg::crc_byte(hunting ? 16'h0000 : crc_q, val);
		move        = s1_valid_q && (!out_valid_q || m_axis_tready);
		rd_en       = (st_q == ST_EMIT) && (rd_q < size_q) && (!s1_valid_q || move);
		// first frame byte is the length byte itself, at address zero
		wr_en       = accept && !is_tick &&
			(!hunting || (val != sfr_pkg::PREAMBLE && pre_q == 2'd2 && len_ok));
		wr_addr     = hunting ? '0 : AW'(fill_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) frame_mem[wr_addr] <= val;
		if (rd_en) rdata_s1 <= frame_mem[AW'(rd_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RUN;
			timeout_q   <= sfr_pkg::TIMEOUT_RESET;
			min_len_q   <= sfr_pkg::MIN_LEN_RESET;
			pre_q       <= '0;
			size_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			crc_q       <= '0;
			ticks_q     <= '0;
			rd_q        <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sfr_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
					sfr_pkg::REG_MIN_LEN: min_len_q <= cfg_data[5:0];
					default: ;
				endcase
			end

			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;

			unique case (st_q)
				ST_RUN: begin
					if (accept) begin
						if (is_tick) begin
							if (!hunting) begin
								if (tick_expire) begin
									out_valid_q <= 1'b1;
									out_kind_q  <= sfr_pkg::KIND_TIMEOUT;
									out_data_q  <= 8'h00;
									out_idx_q   <= 6'(fill_q);
									out_last_q  <= 1'b1;
									pre_q       <= '0;
									size_q      <= '0;
									fill_q      <= '0;
									sum_q       <= '0;
									crc_q       <= '0;
									ticks_q     <= '0;
								end else begin
									ticks_q <= ticks_inc;
								end
							end
						end else if (hunting) begin
							if (val == sfr_pkg::PREAMBLE) begin
								if (pre_q != 2'd2) pre_q <= pre_q + 2'd1;
							end else if (pre_q != 2'd2) begin
								pre_q <= '0;
							end else begin
								pre_q <= '0;
								if (len_ok) begin
									size_q  <= FW'({2'b00, val} + 10'd3);
									sum_q   <= val;
									crc_q   <= crc_next;
									fill_q  <= FW'(1);
									ticks_q <= '0;
								end else begin
									out_valid_q <= 1'b1;
									out_kind_q  <= sfr_pkg::KIND_BAD_LEN;
									out_data_q  <= val;
									out_idx_q   <= 6'd0;
									out_last_q  <= 1'b1;
								end
							end
						end else begin
							if (fill_q < len_w) begin
								sum_q <= sum_q + val;
								crc_q <= crc_next;
							end
							if (fill_q == len_w) sumb_q <= val;
							if (fill_q == len_w + FW'(1)) crch_q <= val;
							fill_q <= fill_inc;
							if (final_byte) begin
								// sum first, then crc high byte, then crc low byte
								if (sum_q != sumb_q) begin
									out_valid_q <= 1'b1;
									out_kind_q  <= sfr_pkg::KIND_BAD_SUM;
									out_data_q  <= sumb_q;
									out_idx_q   <= 6'(len_w);
									out_last_q  <= 1'b1;
									size_q      <= '0;
								end else if (crc_q[15:8] != crch_q) begin
									out_valid_q <= 1'b1;
									out_kind_q  <= sfr_pkg::KIND_BAD_CRC;
									out_data_q  <= crch_q;
									out_idx_q   <= 6'(len_w + FW'(1));
									out_last_q  <= 1'b1;
									size_q      <= '0;
								end else if (crc_q[7:0] != val) begin
									out_valid_q <= 1'b1;
									out_kind_q  <= sfr_pkg::KIND_BAD_CRC;
									out_data_q  <= val;
									out_idx_q   <= 6'(fill_q);
									out_last_q  <= 1'b1;
									size_q      <= '0;
								end else begin
									// size_q is kept for the readout
									st_q <= ST_EMIT;
									rd_q <= '0;
								end
								pre_q   <= '0;
								fill_q  <= '0;
								sum_q   <= '0;
								crc_q   <= '0;
								ticks_q <= '0;
							end
						end
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						s1_valid_q <= 1'b1;
						idx_s1     <= 6'(rd_q);
						last_s1    <= (rd_q == size_q - FW'(1));
						rd_q       <= rd_q + FW'(1);
					end else if (move) begin
						s1_valid_q <= 1'b0;
					end
					if (move) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= sfr_pkg::KIND_BYTE;
						out_data_q  <= rdata_s1;
						out_idx_q   <= idx_s1;
						out_last_q  <= last_s1;
						if (last_s1) begin
							st_q   <= ST_RUN;
							size_q <= '0;
							rd_q   <= '0;
						end
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

endmodule

// ----- design/sfr_checker.sv -----
// port-level checks for the serial frame receiver, bound to the top level
module sfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// no new request is taken while a result waits
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while output stalled");

	// status results are single and always close their run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != sfr_pkg::KIND_BYTE |-> m_axis_tlast)
		else $error("status result without last");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= sfr_pkg::KIND_TIMEOUT
			&& m_axis_tdata[15:14] == 2'b00)
		else $error("bad kind or padding");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- bench/serial_frame_receiver_core_tb.sv -----
// testbench for the serial frame receiver core: frame hunt, length, sum and crc checks, timeouts
module serial_frame_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_CAP     = 64;
	localparam int unsigned LONGEST_BODY  = FRAME_CAP - sfr_pkg::TRAILER_BYTES;
	localparam int unsigned STALL_PCT     = 13;
	localparam int unsigned STUCK_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [1:0]  REG_SPARE_2   = 2'd2;
	localparam logic [1:0]  REG_SPARE_3   = 2'd3;

	typedef enum int unsigned {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_CRC_HI,
		FLAW_CRC_LO,
		FLAW_CUT
	} flaw_t;

	typedef struct {
		sfr_pkg::kind_t kind;
		logic [7:0]     data_byte;
		logic [5:0]     byte_index;
		logic           last;
	} frame_result_t;

	// mirrors the deframer state and holds the results still owed by the block
	class frame_tracker;
		logic [7:0]    held_bytes [FRAME_CAP];
		logic [1:0]    ff_run;
		logic [6:0]    open_size;
		logic [6:0]    fill;
		logic [7:0]    sum;
		logic [15:0]   crc;
		logic [15:0]   ticks;
		logic [15:0]   timeout_limit;
		logic [5:0]    min_len;
		frame_result_t due_results [$];
		int unsigned   errors;

		function new();
			timeout_limit = sfr_pkg::TIMEOUT_RESET;
			min_len = sfr_pkg::MIN_LEN_RESET;
			errors = 0;
			drop_frame();
		endfunction

		// reflected crc-16, fed one bit at a time
		function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = acc;
			for (int n = 0; n < 8; n++) begin
				fb = r[0] ^ b[n];
				r = r >> 1;
				if (fb) r = r ^ sfr_pkg::CRC_POLY;
			end
			return r;
		endfunction

		function void drop_frame();
			ff_run = 0;
			open_size = 0;
			fill = 0;
			sum = 0;
			crc = 0;
			ticks = 0;
		endfunction

		function int unsigned shortest_len();
			return (min_len == 0) ? 1 : min_len;
		endfunction

		function void add_result(sfr_pkg::kind_t k, logic [7:0] d, logic [5:0] idx,
				logic lst);
			frame_result_t r;
			r.kind = k;
			r.data_byte = d;
			r.byte_index = idx;
			r.last = lst;
			due_results.push_back(r);
		endfunction

		function void take_write(logic [1:0] idx, logic [15:0] val);
			if (idx == sfr_pkg::REG_TIMEOUT) timeout_limit = val;
			else if (idx == sfr_pkg::REG_MIN_LEN) min_len = val[5:0];
		endfunction

		function void take_request(logic tick, logic [7:0] b);
			logic [6:0] body_len;
			if (tick) begin
				if (open_size == 0) return;
				if (ticks != 16'hFFFF) ticks++;
				if (ticks >= timeout_limit) begin
					add_result(sfr_pkg::KIND_TIMEOUT, 8'h00, fill[5:0], 1'b1);
					drop_frame();
				end
				return;
			end
			if (open_size == 0) begin
				if (b == sfr_pkg::PREAMBLE) begin
					if (ff_run < 2) ff_run++;
					return;
				end
				if (ff_run < 2) begin
					ff_run = 0;
					return;
				end
				ff_run = 0;
				if (int'(b) <= LONGEST_BODY && int'(b) >= shortest_len()) begin
					open_size = 7'(int'(b) + sfr_pkg::TRAILER_BYTES);
					held_bytes[0] = b;
					sum = b;
					crc = crc_step(16'h0000, b);
					fill = 1;
					ticks = 0;
				end else begin
					add_result(sfr_pkg::KIND_BAD_LEN, b, 6'd0, 1'b1);
				end
				return;
			end
			body_len = open_size - 7'(sfr_pkg::TRAILER_BYTES);
			if (fill < open_size) begin
				held_bytes[fill] = b;
				if (fill < body_len) begin
					sum = sum + b;
					crc = crc_step(crc, b);
				end
				fill++;
			end
			if (fill < open_size) return;
			// sum is judged before either crc byte
			if (sum != held_bytes[body_len])
				add_result(sfr_pkg::KIND_BAD_SUM, held_bytes[body_len], body_len[5:0], 1'b1);
			else if (crc[15:8] != held_bytes[body_len + 1])
				add_result(sfr_pkg::KIND_BAD_CRC, held_bytes[body_len + 1],
					6'(body_len + 1), 1'b1);
			else if (crc[7:0] != held_bytes[body_len + 2])
				add_result(sfr_pkg::KIND_BAD_CRC, held_bytes[body_len + 2],
					6'(body_len + 2), 1'b1);
			else
				for (int k = 0; k < open_size; k++)
					add_result(sfr_pkg::KIND_BYTE, held_bytes[k], 6'(k),
						k == open_size - 1);
			drop_frame();
		endfunction

		function void match_result(logic [2:0] kind, logic [7:0] data_byte,
				logic [5:0] byte_index, logic last, logic [1:0] pad);
			frame_result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d data %02h index %0d last %0d",
					kind, data_byte, byte_index, last);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (data_byte !== want.data_byte) begin
				$error("data_byte: expected %02h, got %02h", want.data_byte, data_byte);
				errors++;
			end
			if (byte_index !== want.byte_index) begin
				$error("byte_index: expected %0d, got %0d", want.byte_index, byte_index);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				errors++;
			end
			if (pad !== 2'b00) begin
				$error("tdata[15:14]: expected 0, got %0d", pad);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_axis_tuser = 1'b0;    // [0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [15:0] m_axis_tdata;           // [7:0] data_byte, [13:8] byte_index, [15:14] zero
	logic [2:0]  m_axis_tuser;           // [2:0] kind
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	frame_tracker tracker = new();
	bit           calm = 1'b0;
	int unsigned  items_sent = 0;
	int unsigned  quiet_cycles = 0;

	serial_frame_receiver_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.match_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
				m_axis_tlast, m_axis_tdata[15:14]);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STUCK_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(logic tick, logic [7:0] b);
		@(negedge clk);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= tick;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.take_request(tick, b);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.take_write(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
	endtask

	// a byte that causes no result may still be in flight once the queue is empty
	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(int unsigned len, flaw_t flaw, int unsigned tick_pct,
			int unsigned nff);
		logic [7:0]  frame_bytes [$];
		logic [7:0]  sum;
		logic [15:0] crc;
		int unsigned keep;
		int unsigned tick_count;
		frame_bytes.push_back(8'(len));
		for (int i = 1; i < len; i++) frame_bytes.push_back(8'($urandom));
		sum = 0;
		crc = 0;
		foreach (frame_bytes[i]) begin
			sum = sum + frame_bytes[i];
			crc = tracker.crc_step(crc, frame_bytes[i]);
		end
		frame_bytes.push_back(sum);
		frame_bytes.push_back(crc[15:8]);
		frame_bytes.push_back(crc[7:0]);
		case (flaw)
			FLAW_SUM: frame_bytes[len] ^= 8'($urandom_range(1, 255));
			FLAW_CRC_HI: frame_bytes[len + 1] ^= 8'($urandom_range(1, 255));
			FLAW_CRC_LO: frame_bytes[len + 2] ^= 8'($urandom_range(1, 255));
			FLAW_CUT: begin
				keep = $urandom_range(1, len + 2);
				while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
			end
			default: ;
		endcase
		repeat (nff) send_request(1'b0, sfr_pkg::PREAMBLE);
		foreach (frame_bytes[i]) begin
			if ($urandom_range(99) < tick_pct) send_request(1'b1, 8'($urandom));
			send_request(1'b0, frame_bytes[i]);
		end
		// a cut frame is left to run out of ticks
		if (flaw == FLAW_CUT) begin
			tick_count = (tracker.timeout_limit == 0) ? 1 : tracker.timeout_limit;
			repeat (tick_count) send_request(1'b1, 8'($urandom));
		end
		items_sent += nff + frame_bytes.size();
	endtask

	task automatic random_traffic(int unsigned target, int unsigned tick_pct);
		int unsigned start;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		int unsigned len;
		flaw_t       flaw;
		start = items_sent;
		while (items_sent - start < target) begin
			lo = tracker.shortest_len();
			hi = (lo + 10 < LONGEST_BODY) ? lo + 10 : LONGEST_BODY;
			pick = $urandom_range(99);
			if (pick < 72) begin
				len = ($urandom_range(3) != 0) ? $urandom_range(lo, hi)
					: $urandom_range(lo, LONGEST_BODY);
				case ($urandom_range(11))
					0: flaw = FLAW_SUM;
					1: flaw = FLAW_CRC_HI;
					2: flaw = FLAW_CRC_LO;
					3: flaw = (tracker.timeout_limit <= 64) ? FLAW_CUT : FLAW_NONE;
					default: flaw = FLAW_NONE;
				endcase
				send_frame(len, flaw, tick_pct, $urandom_range(2, 4));
			end else if (pick < 82) begin
				// length byte outside the accepted range
				send_request(1'b0, sfr_pkg::PREAMBLE);
				send_request(1'b0, sfr_pkg::PREAMBLE);
				if ($urandom_range(1))
					send_request(1'b0, 8'((lo > 1) ? $urandom_range(0, lo - 1) : 0));
				else
					send_request(1'b0, 8'($urandom_range(LONGEST_BODY + 1, 254)));
				items_sent += 3;
			end else begin
				case ($urandom_range(2))
					0: send_request(1'b1, 8'($urandom));
					1: begin
						send_request(1'b0, sfr_pkg::PREAMBLE);
						send_request(1'b0, 8'($urandom_range(0, 254)));
					end
					default: send_request(1'b0, 8'($urandom));
				endcase
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(sfr_pkg::REG_MIN_LEN, 16'd1);
		send_request(1'b1, 8'hA5);                 // tick while hunting
		send_request(1'b0, sfr_pkg::PREAMBLE);     // lone preamble byte, then noise
		send_request(1'b0, 8'h00);
		send_frame(1, FLAW_NONE, 0, 3);
		send_frame(1, FLAW_SUM, 0, 2);
		send_frame(1, FLAW_CRC_HI, 0, 2);
		send_frame(1, FLAW_CRC_LO, 0, 2);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, 8'(LONGEST_BODY + 1));
		settle();
		write_reg(sfr_pkg::REG_TIMEOUT, 16'd2);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, 8'd3);
		send_request(1'b0, 8'h5A);
		send_request(1'b1, 8'hFF);
		send_request(1'b1, 8'h00);
		settle();

		write_reg(sfr_pkg::REG_TIMEOUT, sfr_pkg::TIMEOUT_RESET);
		write_reg(sfr_pkg::REG_MIN_LEN, 16'(sfr_pkg::MIN_LEN_RESET));
		random_traffic(30, 4);
		hold_until_drained();
		random_traffic(30, 4);
		settle();

		// short timeouts, shortest frames, no idling for a while
		write_reg(sfr_pkg::REG_TIMEOUT, 16'($urandom_range(1, 40)));
		write_reg(sfr_pkg::REG_MIN_LEN, 16'd1);
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));
		calm = 1'b1;
		random_traffic(40, 8);
		calm = 1'b0;
		random_traffic(30, 8);
		settle();

		write_reg(sfr_pkg::REG_TIMEOUT, 16'hFFFF);
		write_reg(sfr_pkg::REG_MIN_LEN, 16'(LONGEST_BODY));
		random_traffic(40, 2);
		settle();

		// zero timeout ends a frame on its first tick; zero min length acts as one
		write_reg(sfr_pkg::REG_TIMEOUT, 16'd0);
		write_reg(sfr_pkg::REG_MIN_LEN, 16'd0);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, sfr_pkg::PREAMBLE);
		send_request(1'b0, 8'd1);
		send_request(1'b1, 8'h3C);
		random_traffic(40, 3);

		hold_until_drained();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.due_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sfr_pkg.sv
design/serial_frame_receiver_core.sv
design/sfr_checker.sv
bench/serial_frame_receiver_core_tb.sv
